[rtl/assert_macros.svh]
// Assertion macros shared by the real-mode memory access unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, off while rst is high.
`define RMAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond never holds at a rising edge of clk, off while rst is high.
`define RMAU_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/rmau_pkg.sv]
// Shared types and constants for the real-mode memory access unit.
package rmau_pkg;

  localparam int unsigned MEM_BYTES = 4194304;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);

  // action codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FETCH = 2'd2;

  // access_width codes
  localparam logic [1:0] WID_BYTE  = 2'd0;
  localparam logic [1:0] WID_WORD  = 2'd1;
  localparam logic [1:0] WID_DWORD = 2'd2;

  localparam logic MODE_REAL = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } rmau_state_t;

  typedef struct packed {
    logic       load;    // take the item at the input ports
    logic       issue;   // access one byte of the item
    logic [1:0] lane;    // byte lane being accessed
    logic       finish;  // register the result
  } rmau_cmd_t;

  typedef struct packed {
    logic       empty;      // item at the inputs touches no byte
    logic [1:0] last_lane;  // lane of the final byte of the held item
  } rmau_stat_t;

endpackage

[rtl/rmau_datapath.sv]
// Datapath: address generation, byte memory, result assembly and mode register.
`include "assert_macros.svh"

module rmau_datapath import rmau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rmau_cmd_t   cmd,
  output rmau_stat_t  stat,
  input  logic [1:0]  action,
  input  logic [1:0]  access_width,
  input  logic [15:0] segment,
  input  logic [31:0] offset,
  input  logic [31:0] write_data,
  input  logic        addressing_mode_we,
  input  logic        addressing_mode,
  output logic [31:0] read_data,
  output logic [15:0] next_ip
);

  logic [7:0]  mem [MEM_BYTES];

  logic        mode;
  logic [1:0]  act;
  logic [1:0]  last_lane;
  logic [31:0] base;
  logic [31:0] lin;
  logic [15:0] ip;
  logic [31:0] wdata;
  logic [15:0] nip;
  logic [31:0] acc;
  logic [7:0]  rd_byte;
  logic        pend;
  logic [1:0]  pend_lane;

  logic        supported_in;
  logic        active_in;
  logic [1:0]  last_in;
  logic [31:0] base_in;
  logic [15:0] nip_in;
  logic [31:0] addr;
  logic        in_range;
  logic [31:0] acc_next;

  always_comb begin
    supported_in = 1'b1;
    last_in      = 2'd0;
    case (access_width)
      WID_BYTE:  last_in = 2'd0;
      WID_WORD:  last_in = 2'd1;
      WID_DWORD: last_in = 2'd3;
      default:   supported_in = 1'b0;
    endcase
    active_in = (mode == MODE_REAL) && supported_in &&
                (action inside {ACT_READ, ACT_WRITE, ACT_FETCH});
    base_in   = {12'd0, segment, 4'd0};
    if (active_in && action == ACT_FETCH) begin
      nip_in = offset[15:0] + {13'd0, {1'b0, last_in} + 3'd1};
    end else begin
      nip_in = offset[15:0];
    end
  end

  assign stat.empty     = !active_in;
  assign stat.last_lane = last_lane;

  // byte address of the current lane
  always_comb begin
    if (act == ACT_FETCH) begin
      addr = base + {16'd0, ip + {14'd0, cmd.lane}};
    end else begin
      addr = lin + {30'd0, cmd.lane};
    end
    in_range = addr < MEM_BYTES;
  end

  always_comb begin
    acc_next = acc;
    if (pend) begin
      acc_next[{pend_lane, 3'b000} +: 8] = rd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_REAL;
    end else if (addressing_mode_we) begin
      mode <= addressing_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.issue && act != ACT_WRITE && in_range;
    end
  end

  always_ff @(posedge clk) begin
    pend_lane <= cmd.lane;
    if (cmd.load) begin
      act       <= action;
      last_lane <= last_in;
      base      <= base_in;
      lin       <= base_in + offset;
      ip        <= offset[15:0];
      wdata     <= write_data;
      nip       <= nip_in;
      acc       <= '0;
    end else begin
      acc <= acc_next;
    end
    if (cmd.finish) begin
      read_data <= acc_next;
      next_ip   <= nip;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue && in_range) begin
      if (act == ACT_WRITE) begin
        mem[addr[MEM_AW-1:0]] <= wdata[{cmd.lane, 3'b000} +: 8];
      end else begin
        rd_byte <= mem[addr[MEM_AW-1:0]];
      end
    end
  end

  `RMAU_ASSERT(a_pend_follows_issue, pend |-> $past(cmd.issue), "read byte without an issue")
  `RMAU_NEVER(a_load_during_issue, cmd.load && cmd.issue, "load and issue together")
  `RMAU_NEVER(a_finish_during_issue, cmd.finish && cmd.issue, "finish and issue together")

endmodule

[rtl/rmau_ctrl.sv]
// Controller: sequences the byte accesses of one item and strobes the result.
`include "assert_macros.svh"

module rmau_ctrl import rmau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  input  rmau_stat_t stat,
  output rmau_cmd_t  cmd
);

  rmau_state_t state;
  rmau_state_t state_next;
  logic [1:0]  lane;
  logic [1:0]  lane_next;

  assign busy = state != ST_IDLE;

  always_comb begin
    state_next = state;
    lane_next  = lane;
    case (state)
      ST_IDLE: begin
        lane_next = 2'd0;
        if (start) begin
          state_next = stat.empty ? ST_FLUSH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (lane == stat.last_lane) begin
          state_next = ST_FLUSH;
        end else begin
          lane_next = lane + 2'd1;
        end
      end
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.lane = lane;
    case (state)
      ST_IDLE:  cmd.load   = start;
      ST_RUN:   cmd.issue  = 1'b1;
      ST_FLUSH: cmd.finish = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lane  <= 2'd0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      lane  <= lane_next;
      done  <= cmd.finish;
    end
  end

  `RMAU_ASSERT(a_done_after_flush, done |-> $past(state) == ST_FLUSH, "done without flush")
  `RMAU_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy, "accepted beat not held busy")
  `RMAU_ASSERT(a_lane_bound, state == ST_RUN |-> lane <= stat.last_lane, "lane past last byte")

endmodule

[rtl/real_mode_memory_access_unit.sv]
// Top level of the real-mode segmented memory access unit.
//
// Input channel: an item (action, access_width, segment, offset, write_data)
// is taken at a rising edge where start is high and busy is low. Each item
// gives one result beat: read_data and next_ip are valid for the single cycle
// in which done is high; the receiver cannot stall, so it must take it then.
// Configuration: addressing_mode is written at any edge with
// addressing_mode_we high; write it only while the unit is idle.
// Sequence: an item of n bytes (n = 1, 2 or 4) is accepted, its bytes are
// accessed one at a time through the single-port byte memory, and then the
// last read byte is merged and the result registered together with done.
// Items that touch no byte (unsupported width, unknown action, non-real
// mode) skip the byte accesses. A new item may be accepted in the cycle
// that done is high.
// Reset (rst, synchronous) returns to idle, clears done and sets real mode.
// Memory contents are not cleared and are undefined until written.
module real_mode_memory_access_unit import rmau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  action,
  input  logic [1:0]  access_width,
  input  logic [15:0] segment,
  input  logic [31:0] offset,
  input  logic [31:0] write_data,
  input  logic        addressing_mode_we,
  input  logic        addressing_mode,
  output logic [31:0] read_data,
  output logic [15:0] next_ip
);

  rmau_cmd_t  cmd;
  rmau_stat_t stat;

  rmau_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  rmau_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .action             (action),
    .access_width       (access_width),
    .segment            (segment),
    .offset             (offset),
    .write_data         (write_data),
    .addressing_mode_we (addressing_mode_we),
    .addressing_mode    (addressing_mode),
    .read_data          (read_data),
    .next_ip            (next_ip)
  );

endmodule
